/* design/spectrum_band_envelope_follower_macros.svh */
// Assertion macros shared by the envelope follower RTL.
`ifndef SPECTRUM_BAND_ENVELOPE_FOLLOWER_MACROS_SVH
`define SPECTRUM_BAND_ENVELOPE_FOLLOWER_MACROS_SVH
`ifndef SYNTHESIS
`define SBEF_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SBEF_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define SBEF_CHECK(lbl, prop, msg)
`define SBEF_NEVER(lbl, expr, msg)
`endif
`endif

/* design/sbef_pkg.sv */
// Types and constants of the spectrum band envelope follower.
`timescale 1ns / 1ps
package sbef_pkg;
   localparam int NUM_BANDS = 8;
   localparam int BAND_W = $clog2(NUM_BANDS);

   localparam logic [1:0] CSR_SQUELCH = 2'd0;
   localparam logic [1:0] CSR_ATTACK  = 2'd1;
   localparam logic [1:0] CSR_RELEASE = 2'd2;
   localparam logic [1:0] CSR_DECAY   = 2'd3;

   localparam logic [23:0] SQUELCH_RST = 24'd15360;
   localparam logic [15:0] ATTACK_RST  = 16'd36045;
   localparam logic [15:0] RELEASE_RST = 16'd6554;
   localparam logic [15:0] DECAY_RST   = 16'd65503;

   localparam logic [31:0] FLOOR_RST = 32'hFFFF_FFFF;
   localparam logic [31:0] PEAK_RST  = 32'd256;
   localparam logic [23:0] LPEAK_RST = 24'd3;

   localparam logic [16:0] CREEP_MUL    = 17'd131;
   localparam logic [32:0] CREEP_ADD    = 33'd13;
   localparam logic [32:0] FLOOR_MARGIN = 33'd256;
   localparam logic [16:0] ONE_Q16      = 17'h10000;

   typedef enum logic [3:0] {
      S_IDLE, S_GATE, S_GDIV, S_FLMUL, S_FLUPD, S_PKMUL, S_PKUPD, S_NDIV,
      S_GMUL, S_GUPD, S_SMUL, S_SUPD, S_LPKMUL, S_LPKUPD, S_LDIV, S_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [16:0] quot;
   } div_rsp_type;
endpackage

/* design/sbef_div.sv */
// Iterative divider for clamped Q1.16 ratios, one quotient bit per cycle.
`timescale 1ns / 1ps
module sbef_div import sbef_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [16:0] quot_ff, quot_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [32:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff[31:0], 1'b0};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         den_in = div_req.den;
         // A numerator at or above the divisor means a ratio of at least one.
         if (div_req.num >= div_req.den) begin
            quot_in = ONE_Q16;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {1'b0, div_req.num};
            quot_in = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? shifted - {1'b0, den_ff} : shifted;
         quot_in = {quot_ff[15:0], ge};
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
endmodule

/* design/spectrum_band_envelope_follower.sv */
// Top level of the spectrum band envelope follower.
// Usage:
// One frame (eight band magnitudes and the frame RMS) is a transfer on the
// req_ channel; one result (eight smoothed band levels, the loudness level and
// the unsmoothed bass target) follows as a transfer on the rsp_ channel.
// Registers are written through csr_we/csr_addr/csr_wdata; the user must do this only
// while idle, as the block itself does not enforce it. A frame's work is
// done by the single shared divider, which gives a quotient for the gate, each
// band and the loudness ratio (early when the ratio clamps to 1.0, skipped
// when it is known to be zero), and by the shared multiplier, which gives four
// products per band with a register behind each one.
// A new frame is not taken until the previous one has finished its work.
// req_ready is high only while no frame is in work; a new frame may be taken
// while a finished result still waits in the output register.
// If the receiver stalls, the next frame completes its work and then waits
// until the held result has been transferred.
// Synchronous reset restores the registers to their defaults, sets the noise
// floors to maximum, the band peaks to 256, the loudness peak to its small
// start value and all smoothed levels to zero.
`timescale 1ns / 1ps
`include "spectrum_band_envelope_follower_macros.svh"
module spectrum_band_envelope_follower import sbef_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_band_mag_0,
   input  logic [31:0] req_band_mag_1,
   input  logic [31:0] req_band_mag_2,
   input  logic [31:0] req_band_mag_3,
   input  logic [31:0] req_band_mag_4,
   input  logic [31:0] req_band_mag_5,
   input  logic [31:0] req_band_mag_6,
   input  logic [31:0] req_band_mag_7,
   input  logic [23:0] req_frame_rms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_band_out_0,
   output logic [15:0] rsp_band_out_1,
   output logic [15:0] rsp_band_out_2,
   output logic [15:0] rsp_band_out_3,
   output logic [15:0] rsp_band_out_4,
   output logic [15:0] rsp_band_out_5,
   output logic [15:0] rsp_band_out_6,
   output logic [15:0] rsp_band_out_7,
   output logic [15:0] rsp_level_out,
   output logic [15:0] rsp_bass_target,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);
   state_type state_ff, state_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic        loud_ff, loud_in;
   logic [31:0] mag_ff [NUM_BANDS];
   logic [23:0] rms_ff;
   logic [16:0] gate_ff, gate_in;
   logic [31:0] fl_cur_ff, fl_cur_in;
   logic [16:0] ratio_ff, ratio_in;
   logic [15:0] tgt_ff, tgt_in;
   logic [15:0] bass_ff, bass_in;
   logic [48:0] prod_ff;
   logic [31:0] floor_ff [NUM_BANDS];
   logic [31:0] peak_ff [NUM_BANDS];
   logic [15:0] smooth_ff [NUM_BANDS];
   logic [23:0] lpk_ff, lpk_in;
   logic [15:0] lsm_ff, lsm_in;
   logic [23:0] squelch_ff;
   logic [15:0] attack_ff, release_ff, decay_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_band_ff [NUM_BANDS];
   logic [15:0] rsp_level_ff, rsp_bass_ff;

   logic        accept, out_load;
   logic        floor_we, peak_we, smooth_we;
   logic [31:0] floor_wd, peak_wd;
   logic [15:0] smooth_wd;
   logic [31:0] mul_a;
   logic [16:0] mul_b;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0] mag_cur, fl_old, pk_old, fl_new, margin, decayed, pk_new, creep_sat;
   logic [32:0] creep_sum, margin_sum;
   logic [15:0] s_cur, s_new, d_step, tgt_new;
   logic [31:0] rnd;
   logic [24:0] two_rms;
   logic [23:0] ldec, lpk_new;
   logic        last_band;

   sbef_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      mag_cur    = mag_ff[band_ff];
      fl_old     = floor_ff[band_ff];
      pk_old     = peak_ff[band_ff];
      s_cur      = loud_ff ? lsm_ff : smooth_ff[band_ff];
      creep_sum  = {1'b0, fl_old} + {9'b0, prod_ff[39:16]} + CREEP_ADD;
      creep_sat  = creep_sum[32] ? 32'hFFFF_FFFF : creep_sum[31:0];
      fl_new     = (mag_cur < fl_old) ? mag_cur : creep_sat;
      margin_sum = {1'b0, fl_cur_ff} + FLOOR_MARGIN;
      margin     = margin_sum[32] ? 32'hFFFF_FFFF : margin_sum[31:0];
      decayed    = prod_ff[47:16];
      pk_new     = mag_cur;
      if (decayed > pk_new) pk_new = decayed;
      if (margin > pk_new) pk_new = margin;
      tgt_new    = (prod_ff[33:32] != 2'b00) ? 16'hFFFF : prod_ff[31:16];
      rnd        = prod_ff[31:0] + 32'd32768;
      d_step     = rnd[31:16];
      s_new      = (tgt_ff > s_cur) ? s_cur + d_step : s_cur - d_step;
      two_rms    = {rms_ff, 1'b0};
      ldec       = prod_ff[39:16];
      lpk_new    = (rms_ff > ldec) ? rms_ff : ldec;
      last_band  = (band_ff == BAND_W'(NUM_BANDS - 1));
   end

   always_comb begin
      state_in  = state_ff;
      band_in   = band_ff;
      loud_in   = loud_ff;
      gate_in   = gate_ff;
      fl_cur_in = fl_cur_ff;
      ratio_in  = ratio_ff;
      tgt_in    = tgt_ff;
      bass_in   = bass_ff;
      lpk_in    = lpk_ff;
      lsm_in    = lsm_ff;
      floor_we  = 1'b0;
      floor_wd  = fl_new;
      peak_we   = 1'b0;
      peak_wd   = pk_new;
      smooth_we = 1'b0;
      smooth_wd = s_new;
      mul_a     = fl_old;
      mul_b     = CREEP_MUL;
      div_req   = '0;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               band_in  = '0;
               loud_in  = 1'b0;
               state_in = S_GATE;
            end
         end
         S_GATE: begin
            if (squelch_ff == 24'd0) begin
               gate_in  = ONE_Q16;
               state_in = S_FLMUL;
            end else if (two_rms <= {1'b0, squelch_ff}) begin
               gate_in  = '0;
               state_in = S_FLMUL;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {7'b0, two_rms - {1'b0, squelch_ff}};
               div_req.den   = {8'b0, squelch_ff};
               state_in      = S_GDIV;
            end
         end
         S_GDIV: begin
            if (div_rsp.done) begin
               gate_in  = div_rsp.quot;
               state_in = S_FLMUL;
            end
         end
         S_FLMUL: begin
            state_in = S_FLUPD;
         end
         S_FLUPD: begin
            floor_we  = 1'b1;
            fl_cur_in = fl_new;
            state_in  = S_PKMUL;
         end
         S_PKMUL: begin
            mul_a    = pk_old;
            mul_b    = {1'b0, decay_ff};
            state_in = S_PKUPD;
         end
         S_PKUPD: begin
            peak_we = 1'b1;
            if (mag_cur > fl_cur_ff) begin
               div_req.start = 1'b1;
               div_req.num   = mag_cur - fl_cur_ff;
               div_req.den   = pk_new - fl_cur_ff;
               state_in      = S_NDIV;
            end else begin
               ratio_in = '0;
               state_in = S_GMUL;
            end
         end
         S_NDIV, S_LDIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot;
               state_in = S_GMUL;
            end
         end
         S_GMUL: begin
            mul_a    = {15'b0, ratio_ff};
            mul_b    = gate_ff;
            state_in = S_GUPD;
         end
         S_GUPD: begin
            tgt_in = tgt_new;
            if (!loud_ff && band_ff == '0) bass_in = tgt_new;
            state_in = S_SMUL;
         end
         S_SMUL: begin
            if (tgt_ff > s_cur) begin
               mul_a = {16'b0, tgt_ff - s_cur};
               mul_b = {1'b0, attack_ff};
            end else begin
               mul_a = {16'b0, s_cur - tgt_ff};
               mul_b = {1'b0, release_ff};
            end
            state_in = S_SUPD;
         end
         S_SUPD: begin
            if (loud_ff) begin
               lsm_in   = s_new;
               state_in = S_DONE;
            end else begin
               smooth_we = 1'b1;
               if (last_band) begin
                  state_in = S_LPKMUL;
               end else begin
                  band_in  = band_ff + BAND_W'(1);
                  state_in = S_FLMUL;
               end
            end
         end
         S_LPKMUL: begin
            mul_a    = {8'b0, lpk_ff};
            mul_b    = {1'b0, decay_ff};
            loud_in  = 1'b1;
            state_in = S_LPKUPD;
         end
         S_LPKUPD: begin
            lpk_in = lpk_new;
            if (lpk_new == 24'd0) begin
               ratio_in = '0;
               state_in = S_GMUL;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {8'b0, rms_ff};
               div_req.den   = {8'b0, lpk_new};
               state_in      = S_LDIV;
            end
         end
         S_DONE: begin
            // Hold the finished frame until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         band_ff      <= '0;
         loud_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lpk_ff       <= LPEAK_RST;
         lsm_ff       <= '0;
         squelch_ff   <= SQUELCH_RST;
         attack_ff    <= ATTACK_RST;
         release_ff   <= RELEASE_RST;
         decay_ff     <= DECAY_RST;
         for (int i = 0; i < NUM_BANDS; i++) begin
            floor_ff[i]  <= FLOOR_RST;
            peak_ff[i]   <= PEAK_RST;
            smooth_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         loud_ff  <= loud_in;
         lpk_ff   <= lpk_in;
         lsm_ff   <= lsm_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (floor_we) floor_ff[band_ff] <= floor_wd;
         if (peak_we) peak_ff[band_ff] <= peak_wd;
         if (smooth_we) smooth_ff[band_ff] <= smooth_wd;
         if (csr_we) begin
            case (csr_addr)
               CSR_SQUELCH: squelch_ff <= csr_wdata;
               CSR_ATTACK:  attack_ff  <= csr_wdata[15:0];
               CSR_RELEASE: release_ff <= csr_wdata[15:0];
               CSR_DECAY:   decay_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      gate_ff   <= gate_in;
      fl_cur_ff <= fl_cur_in;
      ratio_ff  <= ratio_in;
      tgt_ff    <= tgt_in;
      bass_ff   <= bass_in;
      prod_ff   <= mul_a * mul_b;
      if (accept) begin
         mag_ff[0] <= req_band_mag_0;
         mag_ff[1] <= req_band_mag_1;
         mag_ff[2] <= req_band_mag_2;
         mag_ff[3] <= req_band_mag_3;
         mag_ff[4] <= req_band_mag_4;
         mag_ff[5] <= req_band_mag_5;
         mag_ff[6] <= req_band_mag_6;
         mag_ff[7] <= req_band_mag_7;
         rms_ff    <= req_frame_rms;
      end
      if (out_load) begin
         for (int i = 0; i < NUM_BANDS; i++) rsp_band_ff[i] <= smooth_ff[i];
         rsp_level_ff <= lsm_in;
         rsp_bass_ff  <= bass_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_band_out_0  = rsp_band_ff[0];
   assign rsp_band_out_1  = rsp_band_ff[1];
   assign rsp_band_out_2  = rsp_band_ff[2];
   assign rsp_band_out_3  = rsp_band_ff[3];
   assign rsp_band_out_4  = rsp_band_ff[4];
   assign rsp_band_out_5  = rsp_band_ff[5];
   assign rsp_band_out_6  = rsp_band_ff[6];
   assign rsp_band_out_7  = rsp_band_ff[7];
   assign rsp_level_out   = rsp_level_ff;
   assign rsp_bass_target = rsp_bass_ff;

   `SBEF_NEVER(a_div_start_busy, div_req.start && div_rsp.busy, "divider restarted while busy")
   `SBEF_CHECK(a_accept_to_gate, accept |=> state_ff == S_GATE, "frame transfer did not start")
   `SBEF_NEVER(a_load_over_held, out_load && rsp_valid_ff && !rsp_ready, "held result overwritten")
   `SBEF_NEVER(a_wait_no_div, (state_ff == S_NDIV || state_ff == S_LDIV || state_ff == S_GDIV)
      && !div_rsp.busy && !div_rsp.done && !$past(div_req.start), "waiting on an idle divider")
endmodule
